FILE: rtl/tcw_pkg.sv
// Package for the text console writer: field widths, codes and defaults.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 11;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd23;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR   = 2'd0,
    CMD_WRITE_CELL = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_READ_CELL  = 2'd3
  } cmd_t;

endpackage

FILE: rtl/text_console_writer.sv
// Text console writer top level: command sequencer, cursor and cell store.
//
// Text-mode console over a COLUMNS x ROWS store of 16-bit cells (color in the
// high byte, character in the low byte), held in one RAM with one write and
// one registered read port. After reset the block blanks the store, one cell
// a cycle, before it takes its first request; the text_color register can be
// written meanwhile. One request is handled at a time and in_stall stays high
// until its result is loaded into the output register. When put_char scrolls,
// it copies the rows up one line, one cell a cycle through the RAM port pair,
// then blanks a row. A new request is taken the cycle after the result
// register loads, even while that result is still stalled.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcw_pkg::COLOR_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]   in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::COLOR_W-1:0] in_cell_color,
  input  logic [tcw_pkg::COL_W-1:0]   in_column,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_position,
  output logic [tcw_pkg::CHAR_W-1:0]  out_read_char,
  output logic [tcw_pkg::COLOR_W-1:0] out_read_color
);

  localparam int CELLS        = COLUMNS * ROWS;
  localparam int AW           = $clog2(CELLS);
  localparam int CW           = $clog2(COLUMNS + 1);
  localparam int RW           = $clog2(ROWS);
  localparam int PW           = $clog2(CELLS + 1);
  localparam int SCROLL_CELLS = (ROWS - 2) * COLUMNS;
  localparam int BLANK_BASE   = (ROWS - 2) * COLUMNS;

  typedef enum logic [12:0] {
    S_INIT   = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_WRAP   = 13'b0000000000100,
    S_CHK    = 13'b0000000001000,
    S_SCROLL = 13'b0000000010000,
    S_DRAIN  = 13'b0000000100000,
    S_BLANK  = 13'b0000001000000,
    S_ACT    = 13'b0000010000000,
    S_WCELL  = 13'b0000100000000,
    S_CLEAR  = 13'b0001000000000,
    S_RADDR  = 13'b0010000000000,
    S_DONE   = 13'b0100000000000,
    S_RDWAIT = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [tcw_pkg::COLOR_W-1:0] text_color_r;

  tcw_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [tcw_pkg::CHAR_W-1:0]  ch_r, ch_nxt;
  logic [tcw_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic [tcw_pkg::COL_W-1:0]   icol_r, icol_nxt;
  logic [tcw_pkg::ROW_W-1:0]   irow_r, irow_nxt;

  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [tcw_pkg::COL_W-1:0]   out_col_r, out_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [tcw_pkg::POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [tcw_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [tcw_pkg::COLOR_W-1:0] out_color_r, out_color_nxt;

  logic                       we, re;
  logic [AW-1:0]              waddr, raddr;
  logic [tcw_pkg::CELL_W-1:0] wdata, rdata;

  logic          in_acc, in_range;
  logic [AW-1:0] in_addr, cur_addr;
  logic [PW-1:0] cur_pos;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign in_range = (32'(icol_r) < COLUMNS) && (32'(irow_r) < ROWS);
  assign in_addr  = AW'(AW'(irow_r) * AW'(COLUMNS) + AW'(icol_r));
  assign cur_addr = AW'(AW'(row_r) * AW'(COLUMNS) + AW'(col_r));
  assign cur_pos  = PW'(PW'(row_r) * PW'(COLUMNS) + PW'(col_r));

  assign out_valid           = out_valid_r;
  assign out_cursor_column   = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_char       = out_char_r;
  assign out_read_color      = out_color_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    color_nxt     = color_r;
    icol_nxt      = icol_r;
    irow_nxt      = irow_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_pos_nxt   = out_pos_r;
    out_char_nxt  = out_char_r;
    out_color_nxt = out_color_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = {text_color_r, tcw_pkg::BLANK_CHAR};
    re            = 1'b0;
    raddr         = idx_r;

    // pending scroll copy: write last cycle's read data one row up
    if (pend_r) begin
      we    = 1'b1;
      waddr = pend_addr_r;
      wdata = rdata;
    end

    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
        if (idx_r == AW'(CELLS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = tcw_pkg::cmd_t'(in_command);
          ch_nxt    = in_char_code;
          color_nxt = in_cell_color;
          icol_nxt  = in_column;
          irow_nxt  = in_row;
          idx_nxt   = '0;
          unique case (tcw_pkg::cmd_t'(in_command))
            tcw_pkg::CMD_PUT_CHAR:   state_nxt = S_WRAP;
            tcw_pkg::CMD_WRITE_CELL: state_nxt = S_WCELL;
            tcw_pkg::CMD_CLEAR:      state_nxt = S_CLEAR;
            tcw_pkg::CMD_READ_CELL:  state_nxt = S_RADDR;
            default:                 state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRAP: begin
        if (32'(col_r) == COLUMNS) begin
          col_nxt = '0;
          row_nxt = RW'(row_r + 1'b1);
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (32'(row_r) == ROWS - 1) begin
          if (SCROLL_CELLS == 0) begin
            idx_nxt   = AW'(BLANK_BASE);
            state_nxt = S_BLANK;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_SCROLL;
          end
        end else begin
          state_nxt = S_ACT;
        end
      end
      S_SCROLL: begin
        re            = 1'b1;
        raddr         = AW'(idx_r + AW'(COLUMNS));
        pend_nxt      = 1'b1;
        pend_addr_nxt = idx_r;
        if (idx_r == AW'(SCROLL_CELLS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end
      S_DRAIN: begin
        idx_nxt   = AW'(BLANK_BASE);
        state_nxt = S_BLANK;
      end
      S_BLANK: begin
        we = 1'b1;
        if (idx_r == AW'(BLANK_BASE + COLUMNS - 1)) begin
          row_nxt   = RW'(row_r - 1'b1);
          state_nxt = S_ACT;
        end else begin
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end
      S_ACT: begin
        priority if (ch_r == tcw_pkg::CH_NEWLINE) begin
          col_nxt = '0;
          row_nxt = RW'(row_r + 1'b1);
        end else if (ch_r == tcw_pkg::CH_RETURN) begin
          col_nxt = '0;
        end else if (ch_r == tcw_pkg::CH_BACKSPACE) begin
          if (col_r != '0) begin
            col_nxt = CW'(col_r - 1'b1);
          end
        end else begin
          if (32'(col_r) < COLUMNS) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {text_color_r, ch_r};
          end
          col_nxt = CW'(col_r + 1'b1);
        end
        state_nxt = S_DONE;
      end
      S_WCELL: begin
        if (in_range) begin
          we    = 1'b1;
          waddr = in_addr;
          wdata = {color_r, ch_r};
        end
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        we = 1'b1;
        if (idx_r == AW'(CELLS - 1)) begin
          idx_nxt   = '0;
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end
      S_RADDR: begin
        if (in_range) begin
          re    = 1'b1;
          raddr = in_addr;
        end
        state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = tcw_pkg::COL_W'(col_r);
          out_row_nxt   = tcw_pkg::ROW_W'(row_r);
          out_pos_nxt   = tcw_pkg::POS_W'(cur_pos);
          if (cmd_r == tcw_pkg::CMD_READ_CELL && in_range) begin
            out_char_nxt  = rdata[tcw_pkg::CHAR_W-1:0];
            out_color_nxt = rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          end else begin
            out_char_nxt  = '0;
            out_color_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      idx_r        <= '0;
      col_r        <= '0;
      row_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      text_color_r <= tcw_pkg::RESET_COLOR;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        text_color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ch_r        <= ch_nxt;
    color_r     <= color_nxt;
    icol_r      <= icol_nxt;
    irow_r      <= irow_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_pos_r   <= out_pos_nxt;
    out_char_r  <= out_char_nxt;
    out_color_r <= out_color_nxt;
  end

endmodule

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sim/tcw_result_checker.sv
// Checker for the text console writer: mirrors the console state and compares every result.
module tcw_result_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tcw_pkg::COLOR_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]   in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::COLOR_W-1:0] in_cell_color,
  input  logic [tcw_pkg::COL_W-1:0]   in_column,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  input  logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  input  logic [tcw_pkg::POS_W-1:0]   out_cursor_position,
  input  logic [tcw_pkg::CHAR_W-1:0]  out_read_char,
  input  logic [tcw_pkg::COLOR_W-1:0] out_read_color,
  output int                          outstanding,
  output int                          failures
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [COL_W-1:0]   cursor_column;
    logic [ROW_W-1:0]   cursor_row;
    logic [POS_W-1:0]   cursor_position;
    logic [CHAR_W-1:0]  read_char;
    logic [COLOR_W-1:0] read_color;
  } console_view_t;

  logic [CELL_W-1:0]  screen [CELLS];
  logic [COLOR_W-1:0] text_color;
  int unsigned        cur_col;
  int unsigned        cur_row;
  console_view_t      expected_views [$];
  int                 fail_count = 0;

  task automatic blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = {text_color, BLANK_CHAR};
  endtask

  task automatic scroll_up();
    for (int y = 1; y < ROWS - 1; y++) begin
      for (int x = 0; x < COLUMNS; x++) screen[(y - 1) * COLUMNS + x] = screen[y * COLUMNS + x];
    end
    for (int x = 0; x < COLUMNS; x++) screen[(ROWS - 2) * COLUMNS + x] = {text_color, BLANK_CHAR};
  endtask

  task automatic print_char(logic [CHAR_W-1:0] ch);
    if (cur_col == COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row == ROWS - 1) begin
      scroll_up();
      cur_row--;
    end
    if (ch == CH_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == CH_RETURN) begin
      cur_col = 0;
    end else if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) cur_col--;
    end else begin
      if (cur_col < COLUMNS && cur_row < ROWS) screen[cur_row * COLUMNS + cur_col] = {text_color, ch};
      cur_col++;
    end
  endtask

  task automatic apply_request(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color,
                               logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    console_view_t view;
    bit            in_range;
    view = '0;
    in_range = (col < COLUMNS) && (row < ROWS);
    case (cmd)
      CMD_PUT_CHAR: begin
        print_char(ch);
      end
      CMD_WRITE_CELL: begin
        if (in_range) screen[row * COLUMNS + col] = {color, ch};
      end
      CMD_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ_CELL: begin
        if (in_range) {view.read_color, view.read_char} = screen[row * COLUMNS + col];
      end
    endcase
    view.cursor_column   = COL_W'(cur_col);
    view.cursor_row      = ROW_W'(cur_row);
    view.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    expected_views.push_back(view);
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    console_view_t head;
    if (!rst_n) begin
      text_color = RESET_COLOR;
      blank_screen();
      cur_col = 0;
      cur_row = 0;
      expected_views.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          head = expected_views.pop_front();
          check_field("cursor_column", head.cursor_column, out_cursor_column);
          check_field("cursor_row", head.cursor_row, out_cursor_row);
          check_field("cursor_position", head.cursor_position, out_cursor_position);
          check_field("read_char", head.read_char, out_read_char);
          check_field("read_color", head.read_color, out_read_color);
        end
      end
      if (cfg_valid && cfg_ready) text_color = cfg_data;
      if (in_valid && !in_stall) begin
        apply_request(cmd_t'(in_command), in_char_code, in_cell_color, in_column, in_row);
      end
    end
    outstanding <= expected_views.size();
    failures <= fail_count;
  end

endmodule

FILE: sim/text_console_writer_tb.sv
// Testbench top for the text console writer: clock, reset, request stimulus and verdict.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int CYCLE_LIMIT = 16_000_000;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [COLOR_W-1:0] cfg_data      = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command    = '0;
  logic [CHAR_W-1:0]  in_char_code  = '0;
  logic [COLOR_W-1:0] in_cell_color = '0;
  logic [COL_W-1:0]   in_column     = '0;
  logic [ROW_W-1:0]   in_row        = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [COL_W-1:0]   out_cursor_column;
  logic [ROW_W-1:0]   out_cursor_row;
  logic [POS_W-1:0]   out_cursor_position;
  logic [CHAR_W-1:0]  out_read_char;
  logic [COLOR_W-1:0] out_read_color;

  int outstanding;
  int failures;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent        = 0;
  int cycle_count = 0;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_char_code(in_char_code), .in_cell_color(in_cell_color),
    .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cursor_column(out_cursor_column), .out_cursor_row(out_cursor_row),
    .out_cursor_position(out_cursor_position),
    .out_read_char(out_read_char), .out_read_color(out_read_color)
  );

  tcw_result_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) result_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_char_code(in_char_code), .in_cell_color(in_cell_color),
    .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cursor_column(out_cursor_column), .out_cursor_row(out_cursor_row),
    .out_cursor_position(out_cursor_position),
    .out_read_char(out_read_char), .out_read_color(out_read_color),
    .outstanding(outstanding), .failures(failures)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic send_request(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color,
                              logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_code  <= ch;
    in_cell_color <= color;
    in_column     <= col;
    in_row        <= row;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic type_char(logic [CHAR_W-1:0] ch);
    send_request(CMD_PUT_CHAR, ch, COLOR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic write_at(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                          logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color);
    send_request(CMD_WRITE_CELL, ch, color, col, row);
  endtask

  task automatic read_at(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    send_request(CMD_READ_CELL, CHAR_W'($urandom), COLOR_W'($urandom), col, row);
  endtask

  task automatic clear_screen();
    send_request(CMD_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), COL_W'($urandom),
                 ROW_W'($urandom));
  endtask

  task automatic read_anywhere();
    read_at(COL_W'($urandom_range(COLUMNS - 1)), ROW_W'($urandom_range(ROWS - 1)));
  endtask

  // sender holds off until every pending request has its result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_text_color(logic [COLOR_W-1:0] color);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_phase(int phase);
    case (phase)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 80; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 80; end
      default: begin idle_pct = 16; stall_pct <= 16; end
    endcase
  endtask

  initial begin
    int   target;
    int   n;
    int   r;
    cmd_t cmd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: blank store, corners, out-of-range cells, control codes
    read_at('0, '0);
    read_at(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    read_at('1, '1);
    write_at(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1), 8'hFF, 8'hFF);
    read_at(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    write_at(COL_W'(COLUMNS), '0, 8'h41, 8'h00);
    write_at('0, ROW_W'(ROWS), 8'h42, 8'h00);
    read_at(COL_W'(COLUMNS), '0);
    read_at('0, ROW_W'(ROWS));
    type_char(8'h00);
    type_char(8'hFF);
    type_char(CH_BACKSPACE);
    type_char(CH_RETURN);
    type_char(CH_BACKSPACE);
    type_char(CH_NEWLINE);
    read_at('0, '0);
    read_at(COL_W'(1), '0);
    write_at('0, '0, 8'h00, 8'h00);
    read_at('0, '0);
    clear_screen();
    read_at(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    read_at('0, '0);

    for (int chunk = 0; chunk < 8; chunk++) begin
      wait_drained();
      case (chunk)
        0: set_text_color(8'h00);
        1: set_text_color(8'hFF);
        5: set_text_color(RESET_COLOR);
        default: set_text_color(COLOR_W'($urandom));
      endcase
      set_phase(chunk % 4);
      target = sent + 150;
      while (sent < target) begin
        case ($urandom_range(9))
          0: begin
            n = $urandom_range(1, 10);
            repeat (n) begin
              cmd = cmd_t'($urandom_range(3));
              if (cmd == CMD_CLEAR && $urandom_range(3) != 0) cmd = CMD_READ_CELL;
              send_request(cmd, CHAR_W'($urandom), COLOR_W'($urandom), COL_W'($urandom),
                           ROW_W'($urandom));
            end
          end
          1, 2, 3: begin
            n = $urandom_range(1, 100);
            repeat (n) begin
              r = $urandom_range(99);
              if (r < 5) type_char(CH_NEWLINE);
              else if (r < 8) type_char(CH_RETURN);
              else if (r < 11) type_char(CH_BACKSPACE);
              else if (r < 25) read_anywhere();
              else type_char(CHAR_W'($urandom));
            end
          end
          4, 5: begin
            // walk down toward the bottom row; the longer walks scroll
            clear_screen();
            n = $urandom_range(ROWS - 5, ROWS + 1);
            repeat (n) begin
              type_char(CH_NEWLINE);
              if ($urandom_range(1)) type_char(CHAR_W'($urandom_range(32, 255)));
            end
            repeat ($urandom_range(1, 4)) type_char(CHAR_W'($urandom_range(32, 255)));
            repeat ($urandom_range(2, 5)) begin
              read_at(COL_W'($urandom_range(3)), ROW_W'($urandom_range(ROWS - 5, ROWS - 1)));
            end
          end
          6, 7: begin
            // full line leaves a wrap pending
            type_char(CH_RETURN);
            repeat (COLUMNS) type_char(CHAR_W'($urandom_range(32, 255)));
            read_anywhere();
            case ($urandom_range(4))
              0: type_char(CH_BACKSPACE);
              1: type_char(CH_NEWLINE);
              2: type_char(CH_RETURN);
              3: type_char(CHAR_W'($urandom_range(32, 255)));
              default: write_at(COL_W'($urandom_range(COLUMNS - 1)),
                                ROW_W'($urandom_range(ROWS - 1)),
                                CHAR_W'($urandom), COLOR_W'($urandom));
            endcase
            read_anywhere();
          end
          8: begin
            n = $urandom_range(1, 8);
            repeat (n) begin
              col = COL_W'($urandom_range(COLUMNS - 1));
              row = ROW_W'($urandom_range(ROWS - 1));
              write_at(col, row, CHAR_W'($urandom), COLOR_W'($urandom));
              if ($urandom_range(1)) read_at(col, row);
            end
          end
          default: begin
            clear_screen();
            repeat ($urandom_range(1, 3)) read_anywhere();
          end
        endcase
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: text_console_writer.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
sim/tcw_result_checker.sv
sim/text_console_writer_tb.sv
